>>> sv/par3d_pkg.sv
// ----------------------------------------------------------------------------
// par3d_pkg: shared types and constants for the 3D axis rotation block
// Field widths, axis selector codes, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package par3d_pkg;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 32;
    localparam int OP_W    = 2;
    localparam int FRAC_W  = 16;
    // working width of the rotated pair: 48 bits after gain, plus growth
    localparam int WORK_W  = 50;
    // residual angle width
    localparam int RES_W   = 33;

    typedef logic [OP_W-1:0]           op_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ANGLE_W-1:0]        angle_t;

    localparam op_t AXIS_YAW   = 2'd0;
    localparam op_t AXIS_PITCH = 2'd1;
    localparam op_t AXIS_ROLL  = 2'd2;

    // CORDIC gain compensation in Q0.32 and its finite stage correction
    localparam logic [31:0] GAIN_BASE = 32'h9B74EDA8;
    localparam logic [63:0] GAIN_CORR = 64'd1738754331;

    typedef struct packed {
        op_t    op;
        coord_t x;
        coord_t y;
        coord_t z;
    } par3d_meta_t;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

`default_nettype wire

>>> sv/par3d_if.sv
// ----------------------------------------------------------------------------
// par3d_if: valid/ready channels of the 3D axis rotation block
// Point channel into the block and rotated point channel out of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface par3d_in_if;
    import par3d_pkg::*;

    logic   valid;
    logic   ready;
    op_t    op;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    angle_t turn_angle;

    modport source (output valid, output op, output coord_x, output coord_y,
                    output coord_z, output turn_angle, input ready);
    modport sink   (input valid, input op, input coord_x, input coord_y,
                    input coord_z, input turn_angle, output ready);
endinterface

interface par3d_out_if;
    import par3d_pkg::*;

    logic   valid;
    logic   ready;
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;

    modport source (output valid, output rot_x, output rot_y, output rot_z,
                    input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                    output ready);
endinterface

`default_nettype wire

>>> sv/point_axis_rotation_3d.sv
// ----------------------------------------------------------------------------
// point_axis_rotation_3d: rotate a Q16.16 point about the x, y or z axis
// Pipeline: gain multiply, quadrant fold, one CORDIC step per stage, round.
// Throughput one transaction per cycle; a stalled output holds, bubbles are squeezed out.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_axis_rotation_3d #(
    parameter int ITERATIONS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    par3d_in_if.sink          point,
    par3d_out_if.source       result
);
    import par3d_pkg::*;

    // Gain with the finite stage correction folded in at elaboration.
    localparam logic [63:0] GAIN_ADJ =
        (2 * ITERATIONS < 64) ? (GAIN_CORR >> (2 * ITERATIONS)) : 64'd0;
    localparam logic [31:0] GAIN     = GAIN_BASE + GAIN_ADJ[31:0];
    localparam int PROD_W = 64;
    localparam int SCL_W  = PROD_W - FRAC_W;
    localparam logic signed [PROD_W:0] GAIN_S = {{(PROD_W-31){1'b0}}, GAIN};

    // ------------------------------------------------------------------------
    // Stage 1: pick the plane pair and scale both by the CORDIC gain.
    // Roll works on (z, x) so that the file's sign convention holds.
    // ------------------------------------------------------------------------
    coord_t                    pa;
    coord_t                    pb;
    logic signed [PROD_W:0]    prod_a_full;
    logic signed [PROD_W:0]    prod_b_full;

    logic                      v1_reg;
    par3d_meta_t               meta1_reg;
    angle_t                    angle1_reg;
    logic signed [PROD_W-1:0]  prod_a_reg;
    logic signed [PROD_W-1:0]  prod_b_reg;

    // stage load enables, chained back from the output register
    logic                      ld1;
    logic                      ld [0:ITERATIONS];
    logic                      ld_out;

    always_comb
    begin
        case (point.op)
            AXIS_PITCH:
            begin
                pa = point.coord_y;
                pb = point.coord_z;
            end
            AXIS_ROLL:
            begin
                pa = point.coord_z;
                pb = point.coord_x;
            end
            default:
            begin
                pa = point.coord_x;
                pb = point.coord_y;
            end
        endcase
    end

    assign prod_a_full = $signed({{(PROD_W+1-COORD_W){pa[COORD_W-1]}}, pa}) * GAIN_S;
    assign prod_b_full = $signed({{(PROD_W+1-COORD_W){pb[COORD_W-1]}}, pb}) * GAIN_S;

    assign ld1         = !v1_reg || ld[0];
    assign point.ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ld1)
        begin
            v1_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && point.valid)
        begin
            meta1_reg.op <= point.op;
            meta1_reg.x  <= point.coord_x;
            meta1_reg.y  <= point.coord_y;
            meta1_reg.z  <= point.coord_z;
            angle1_reg   <= point.turn_angle;
            prod_a_reg   <= prod_a_full[PROD_W-1:0];
            prod_b_reg   <= prod_b_full[PROD_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: drop the 16 fraction bits of the product, fold the angle
    // into [-1/8, 1/8) turn and pre-rotate the pair by whole quarter turns.
    // ------------------------------------------------------------------------
    logic signed [WORK_W-1:0]  sa;
    logic signed [WORK_W-1:0]  sb;
    angle_t                    ang_bias;
    logic [1:0]                quad;
    angle_t                    res_u;
    logic signed [WORK_W-1:0]  a0_next;
    logic signed [WORK_W-1:0]  b0_next;

    // CORDIC pipeline: index 0 holds the folded pair, index k the pair
    // after k micro-rotations.
    logic                      cv_reg [0:ITERATIONS];
    par3d_meta_t               cm_reg [0:ITERATIONS];
    logic signed [WORK_W-1:0]  ca_reg [0:ITERATIONS];
    logic signed [WORK_W-1:0]  cb_reg [0:ITERATIONS];
    logic signed [RES_W-1:0]   cz_reg [0:ITERATIONS];

    assign sa       = {{(WORK_W-SCL_W){prod_a_reg[PROD_W-1]}},
                       prod_a_reg[PROD_W-1:FRAC_W]};
    assign sb       = {{(WORK_W-SCL_W){prod_b_reg[PROD_W-1]}},
                       prod_b_reg[PROD_W-1:FRAC_W]};
    assign ang_bias = angle1_reg + 32'h2000_0000;
    assign quad     = ang_bias[31:30];
    assign res_u    = angle1_reg - {quad, 30'd0};

    always_comb
    begin
        case (quad)
            2'd1:
            begin
                a0_next = -sb;
                b0_next = sa;
            end
            2'd2:
            begin
                a0_next = -sa;
                b0_next = -sb;
            end
            2'd3:
            begin
                a0_next = sb;
                b0_next = -sa;
            end
            default:
            begin
                a0_next = sa;
                b0_next = sb;
            end
        endcase
    end

    assign ld[0] = !cv_reg[0] || ld[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (ld[0])
        begin
            cv_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0] && v1_reg)
        begin
            cm_reg[0] <= meta1_reg;
            ca_reg[0] <= a0_next;
            cb_reg[0] <= b0_next;
            cz_reg[0] <= {res_u[31], res_u};
        end
    end

    // ------------------------------------------------------------------------
    // CORDIC rotation stages: one micro-rotation per register stage, the
    // direction taken from the sign of the residual angle.
    // ------------------------------------------------------------------------
    for (genvar k = 1; k <= ITERATIONS; k++)
    begin : g_iter
        logic signed [WORK_W-1:0] da;
        logic signed [WORK_W-1:0] db;
        logic signed [RES_W-1:0]  step;
        logic signed [WORK_W-1:0] a_next;
        logic signed [WORK_W-1:0] b_next;
        logic signed [RES_W-1:0]  z_next;

        assign da   = cb_reg[k-1] >>> (k - 1);
        assign db   = ca_reg[k-1] >>> (k - 1);
        assign step = $signed({1'b0, ATAN_TAB[k-1]});

        always_comb
        begin
            if (!cz_reg[k-1][RES_W-1])
            begin
                a_next = ca_reg[k-1] - da;
                b_next = cb_reg[k-1] + db;
                z_next = cz_reg[k-1] - step;
            end
            else
            begin
                a_next = ca_reg[k-1] + da;
                b_next = cb_reg[k-1] - db;
                z_next = cz_reg[k-1] + step;
            end
        end

        if (k == ITERATIONS)
        begin : g_last
            assign ld[k] = !cv_reg[k] || ld_out;
        end
        else
        begin : g_mid
            assign ld[k] = !cv_reg[k] || ld[k+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[k] <= 1'b0;
            end
            else if (ld[k])
            begin
                cv_reg[k] <= cv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[k] && cv_reg[k-1])
            begin
                cm_reg[k] <= cm_reg[k-1];
                ca_reg[k] <= a_next;
                cb_reg[k] <= b_next;
                cz_reg[k] <= z_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: round to Q16.16, saturate and place the pair back on
    // its axes; the untouched coordinate passes straight through.
    // ------------------------------------------------------------------------
    localparam int RND_W = WORK_W + 1 - FRAC_W;

    function automatic coord_t round_sat(input logic signed [WORK_W-1:0] v);
        logic signed [WORK_W:0]  s;
        logic [RND_W-1:0]        r;
        coord_t                  q;
        s = {v[WORK_W-1], v}
            + $signed({{(WORK_W+1-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
        r = s[WORK_W:FRAC_W];
        if ((&r[RND_W-1:COORD_W-1]) || !(|r[RND_W-1:COORD_W-1]))
        begin
            q = r[COORD_W-1:0];
        end
        else if (r[RND_W-1])
        begin
            q = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            q = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return q;
    endfunction

    coord_t      fa;
    coord_t      fb;
    par3d_meta_t mo;
    coord_t      rot_x_next;
    coord_t      rot_y_next;
    coord_t      rot_z_next;

    logic        out_v_reg;
    coord_t      rot_x_reg;
    coord_t      rot_y_reg;
    coord_t      rot_z_reg;

    assign fa = round_sat(ca_reg[ITERATIONS]);
    assign fb = round_sat(cb_reg[ITERATIONS]);
    assign mo = cm_reg[ITERATIONS];

    always_comb
    begin
        rot_x_next = mo.x;
        rot_y_next = mo.y;
        rot_z_next = mo.z;
        case (mo.op)
            AXIS_YAW:
            begin
                rot_x_next = fa;
                rot_y_next = fb;
            end
            AXIS_PITCH:
            begin
                rot_y_next = fa;
                rot_z_next = fb;
            end
            AXIS_ROLL:
            begin
                rot_z_next = fa;
                rot_x_next = fb;
            end
            default:
            begin
                // undefined axis: hold all three coordinates as they came
                rot_x_next = mo.x;
            end
        endcase
    end

    // The output register takes a new transaction whenever it is empty or
    // being drained; a stall ripples back through the stage load enables.
    assign ld_out = !out_v_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            out_v_reg <= cv_reg[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out && cv_reg[ITERATIONS])
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
            rot_z_reg <= rot_z_next;
        end
    end

    assign result.valid = out_v_reg;
    assign result.rot_x = rot_x_reg;
    assign result.rot_y = rot_y_reg;
    assign result.rot_z = rot_z_reg;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_axis_rotation_3d
// Drives Q16.16 points with binary angles through yaw, pitch, roll and the
// pass-through selector. A directed table comes first, then random points
// under three handshake pressure profiles. Every result is checked against a
// bit-accurate CORDIC predictor kept in this bench or a typed expected value.
// ----------------------------------------------------------------------------
module tb;
    import par3d_pkg::*;

    // Match the block's default stage count so the predictor sees the same
    // residual error.
    localparam int STAGES = 24;
    localparam int RANDOM_PER_PHASE = 600;
    localparam int CYCLE_LIMIT = 100_000;
    // Settle time after the last expected result, sized from the pipeline depth.
    localparam int DRAIN_CYCLES = 2 * (STAGES + 3) + 8;

    // The selector value with no axis behind it: all coordinates pass through.
    localparam op_t AXIS_NONE = 2'd3;

    localparam coord_t Q_MAX = 32'sh7FFF_FFFF;
    localparam coord_t Q_MIN = 32'sh8000_0000;
    localparam coord_t Q_ONE = 32'sh0001_0000;

    // Gain compensation in Q0.32, with the finite stage correction applied
    // only while its shift stays inside 64 bits.
    localparam longint ROT_GAIN = 64'd2608131496
        + ((2 * STAGES < 64) ? (64'd1738754331 >> (2 * STAGES)) : 64'd0);

    // Arctangent of 2^-i in binary angle units (2^32 per turn).
    localparam longint ARCTAN [32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
        64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
    };

    typedef struct {
        op_t    op;
        coord_t x;
        coord_t y;
        coord_t z;
        angle_t angle;
    } stim_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // One row of the directed table. Rows flagged typed carry a result that
    // is obvious by inspection; all others go through the predictor.
    typedef struct {
        stim_t  pt;
        bit     typed;
        point_t want;
    } steer_row_t;

    localparam int N_DIRECTED = 22;

    steer_row_t directed_rows [N_DIRECTED] = '{
        // zero angle still runs the full CORDIC, small rounding allowed
        '{'{AXIS_YAW,   Q_ONE, 32'sh0, 32'sh0005_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
        // quarter, half and three-quarter turns
        '{'{AXIS_YAW,   Q_ONE, 32'sh0, 32'sh0, 32'h4000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_YAW,   Q_ONE, Q_ONE, 32'sh0, 32'h8000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_YAW,   Q_ONE, 32'sh0, 32'sh0, 32'hC000_0000}, 1'b0, '{0, 0, 0}},
        // either side of the quadrant fold boundary
        '{'{AXIS_YAW,   Q_ONE, 32'sh0, 32'sh0, 32'h2000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_YAW,   Q_ONE, 32'sh0, 32'sh0, 32'h1FFF_FFFF}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_YAW,   Q_ONE, Q_ONE, 32'sh0, 32'hDFFF_FFFF}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_YAW,   Q_ONE, 32'sh0, 32'sh0, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_PITCH, 32'sh0, Q_MAX, Q_MIN, 32'h1000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_PITCH, 32'sh0003_0000, Q_ONE, 32'sh0002_0000, 32'h4000_0000},
          1'b0, '{0, 0, 0}},
        // roll sign convention: x rotates toward -z
        '{'{AXIS_ROLL,  Q_ONE, 32'sh0004_0000, 32'sh0, 32'h4000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_ROLL,  Q_MIN, 32'sh0, Q_MIN, 32'h6000_0000}, 1'b0, '{0, 0, 0}},
        // saturation at both ends of the range
        '{'{AXIS_YAW,   Q_MAX, Q_MAX, 32'sh0, 32'h2000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_YAW,   Q_MIN, Q_MIN, 32'sh0, 32'h2000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_ROLL,  Q_MAX, 32'sh0, Q_MIN, 32'hE000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_YAW,   Q_MIN, 32'sh0, 32'sh0, 32'h8000_0000}, 1'b0, '{0, 0, 0}},
        '{'{AXIS_PITCH, Q_MAX, 32'shFFFF_FFFF, 32'sh1, 32'h0000_0001}, 1'b0, '{0, 0, 0}},
        // undefined selector passes every coordinate through
        '{'{AXIS_NONE,  Q_MAX, Q_MIN, 32'sh1234_5678, 32'h4000_0000},
          1'b1, '{Q_MAX, Q_MIN, 32'sh1234_5678}},
        '{'{AXIS_NONE,  32'shFFFF_FFFF, 32'sh0, Q_MIN, 32'hFFFF_FFFF},
          1'b1, '{32'shFFFF_FFFF, 32'sh0, Q_MIN}},
        // a point at the origin stays there whatever the angle
        '{'{AXIS_YAW,   32'sh0, 32'sh0, 32'sh0, 32'h9000_0000}, 1'b1, '{0, 0, 0}},
        '{'{AXIS_ROLL,  32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF}, 1'b1, '{0, 0, 0}},
        '{'{AXIS_PITCH, 32'sh0, 32'sh0, 32'sh0, 32'h7FFF_FFFF}, 1'b1, '{0, 0, 0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    par3d_in_if  point_if ();
    par3d_out_if result_if ();

    point_axis_rotation_3d #(
        .ITERATIONS(STAGES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .result (result_if)
    );

    // Rotated points still owed by the block, oldest first.
    point_t rotated_q [$];

    int src_idle_pct  = 13;
    int snk_stall_pct = 72;
    int mismatch_cnt  = 0;
    int points_sent   = 0;
    int points_checked = 0;
    int axis_count [4] = '{0, 0, 0, 0};
    int cycle_cnt     = 0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Round Q.32 back to Q16.16 and clamp to the signed 32 bit range.
    function automatic coord_t round_sat(longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd2147483647)
            return Q_MAX;
        if (r < -64'sd2147483648)
            return Q_MIN;
        return coord_t'(r);
    endfunction

    // Rotate the pair (a, b) by the binary angle: a' = a c - b s,
    // b' = a s + b c, with the gain folded in up front.
    function automatic void spin_pair(inout longint a, inout longint b, input angle_t ang);
        logic [1:0] quad;
        angle_t     folded;
        longint     resid;
        longint     t;
        longint     da;
        longint     db;
        int         s;
        a = (a * ROT_GAIN) >>> 16;
        b = (b * ROT_GAIN) >>> 16;
        folded = ang + 32'h2000_0000;
        quad = folded[31:30];
        folded = ang - {quad, 30'd0};
        resid = longint'($signed(folded));
        // pre-rotate by whole quarter turns so the residual fits the CORDIC range
        case (quad)
            2'd1:
            begin
                t = a; a = -b; b = t;
            end
            2'd2:
            begin
                a = -a; b = -b;
            end
            2'd3:
            begin
                t = a; a = b; b = -t;
            end
            default: ;
        endcase
        for (int i = 0; i < STAGES; i++)
        begin
            s = i % 32;
            da = b >>> s;
            db = a >>> s;
            if (resid >= 0)
            begin
                a -= da;
                b += db;
                resid -= ARCTAN[s];
            end
            else
            begin
                a += da;
                b -= db;
                resid += ARCTAN[s];
            end
        end
    endfunction

    function automatic point_t rotate_point(stim_t s);
        point_t p;
        longint a;
        longint b;
        p.x = s.x;
        p.y = s.y;
        p.z = s.z;
        case (s.op)
            AXIS_YAW:
            begin
                a = s.x; b = s.y;
                spin_pair(a, b, s.angle);
                p.x = round_sat(a);
                p.y = round_sat(b);
            end
            AXIS_PITCH:
            begin
                a = s.y; b = s.z;
                spin_pair(a, b, s.angle);
                p.y = round_sat(a);
                p.z = round_sat(b);
            end
            AXIS_ROLL:
            begin
                a = s.z; b = s.x;
                spin_pair(a, b, s.angle);
                p.z = round_sat(a);
                p.x = round_sat(b);
            end
            default: ;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Mostly random magnitudes across the whole dynamic range, with the
    // range ends and zero thrown in now and then.
    function automatic coord_t rand_coord();
        case ($urandom_range(15))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 32'sh0;
            3, 4, 5: return coord_t'($urandom);
            default: return coord_t'($signed($urandom) >>> $urandom_range(31));
        endcase
    endfunction

    // Drive one transaction: idle at random first, then hold valid and the
    // payload until the block takes it, and record what must come back.
    task automatic send_point(stim_t s, bit typed, point_t want);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            point_if.valid <= 1'b0;
            @(negedge clk);
        end
        point_if.valid      <= 1'b1;
        point_if.op         <= s.op;
        point_if.coord_x    <= s.x;
        point_if.coord_y    <= s.y;
        point_if.coord_z    <= s.z;
        point_if.turn_angle <= s.angle;
        do
            @(posedge clk);
        while (!point_if.ready);
        rotated_q.push_back(typed ? want : rotate_point(s));
        points_sent++;
        axis_count[s.op]++;
    endtask

    // Back-pressure on the result channel, redrawn every falling edge.
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_field(string name, coord_t want, coord_t got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Compare each completed transaction with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        point_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (rotated_q.size() == 0)
            begin
                $error("unexpected result: rot_x %h rot_y %h rot_z %h",
                       result_if.rot_x, result_if.rot_y, result_if.rot_z);
                mismatch_cnt++;
            end
            else
            begin
                want = rotated_q.pop_front();
                report_field("rot_x", want.x, result_if.rot_x);
                report_field("rot_y", want.y, result_if.rot_y);
                report_field("rot_z", want.z, result_if.rot_z);
                points_checked++;
            end
        end
    end

    // Hard stop in case the pipeline hangs.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, rotated_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        stim_t  s;
        point_t none;
        none = '{0, 0, 0};

        // Hold every input at a known value through reset.
        point_if.valid      = 1'b0;
        point_if.op         = AXIS_YAW;
        point_if.coord_x    = '0;
        point_if.coord_y    = '0;
        point_if.coord_z    = '0;
        point_if.turn_angle = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table under the first pressure profile.
        for (int i = 0; i < N_DIRECTED; i++)
            send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);

        // Random points: slow receiver, then slow sender, then full rate.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 13; snk_stall_pct = 72;
                end
                1:
                begin
                    src_idle_pct = 72; snk_stall_pct = 13;
                end
                default:
                begin
                    src_idle_pct = 0; snk_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Mostly real rotations, an occasional undefined selector.
                s.op = ($urandom_range(15) == 0) ? AXIS_NONE : op_t'($urandom_range(2));
                s.x = rand_coord();
                s.y = rand_coord();
                s.z = rand_coord();
                // Land near a quadrant fold boundary every so often.
                if ($urandom_range(7) == 0)
                    s.angle = {2'($urandom_range(3)), 30'h2000_0000}
                              + angle_t'($urandom_range(4)) - 32'd2;
                else
                    s.angle = $urandom;
                send_point(s, 1'b0, none);
            end
        end

        // Drop valid once the last transaction is in.
        @(negedge clk);
        point_if.valid <= 1'b0;

        // Drain owed results, then give stray outputs a chance to show.
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d points: %0d directed, %0d random",
                 points_checked, points_sent, N_DIRECTED, points_sent - N_DIRECTED);
        $display("By selector: yaw %0d, pitch %0d, roll %0d, pass-through %0d",
                 axis_count[AXIS_YAW], axis_count[AXIS_PITCH],
                 axis_count[AXIS_ROLL], axis_count[AXIS_NONE]);
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
sv/par3d_pkg.sv
sv/par3d_if.sv
sv/point_axis_rotation_3d.sv
test/tb.sv
